@@ src/mbe_pkg.sv @@
package mbe_pkg;

   localparam int FRAC_BITS = 28;
   localparam int COORD_BITS_DEF = 32;
   localparam int COUNT_BITS_DEF = 16;
   localparam int PIXEL_BITS_DEF = 12;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [30:0] VIEW_WIDTH_RST = 31'h3800_0000;
   localparam logic [31:0] ZOOM_RST = 32'h0001_0000;
   localparam logic [15:0] LIMIT_RST = 16'd256;
   localparam logic [12:0] FRAME_WIDTH_RST = 13'd800;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd600;
   localparam logic [31:0] THREE_QUARTERS = 32'h0C00_0000;
   // ceil(2^33/3): floor(n/3) = (n * THIRD_RECIP) >> 33 for any 32-bit n
   localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VIEW_WIDTH = 3'd0,
      CSR_ZOOM       = 3'd1,
      CSR_X_OFFSET   = 3'd2,
      CSR_Y_OFFSET   = 3'd3,
      CSR_LIMIT      = 3'd4,
      CSR_FRAME_W    = 3'd5,
      CSR_FRAME_H    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE, F_VH, F_XQ, F_YQ, F_XZ, F_YZ, F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE, B_CHECK, B_UPDATE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ src/mbe_div.sv @@
module mbe_div #(
   parameter int NUM_BITS = 60
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [31:0]         den,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(NUM_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [32:0]         rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [31:0]         den_ff, den_in;
   logic [32:0]         rem_sh;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      rem_sh = {rem_ff[31:0], quo_ff[NUM_BITS-1]};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = CNT_BITS'(NUM_BITS - 1);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

@@ src/mbe_front.sv @@
module mbe_front #(
   parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
   parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [PIXEL_BITS-1:0]        pixel_column,
   input  logic [PIXEL_BITS-1:0]        pixel_row,
   output logic                         busy,
   input  logic [30:0]                  view_width,
   input  logic [31:0]                  zoom_factor,
   input  logic signed [31:0]           x_offset,
   input  logic signed [31:0]           y_offset,
   input  logic [12:0]                  frame_width,
   input  logic [12:0]                  frame_height,
   input  mbe_pkg::queue_status_type    q_status,
   output logic                         q_push,
   output logic [2*COORD_BITS-1:0]      q_data
);

   localparam int NUM_BITS = 48 + PIXEL_BITS;
   localparam int WW = ((NUM_BITS > COORD_BITS) ? NUM_BITS : COORD_BITS) + 2;
   localparam logic signed [WW-1:0] CMAX_W =
      {{(WW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [WW-1:0] CMIN_W = ~CMAX_W;

   mbe_pkg::front_state_type state_ff, state_in;
   logic                       go_ff, go_in;
   logic [PIXEL_BITS-1:0]      col_ff, row_ff;
   logic [30:0]                vh_ff;
   logic signed [NUM_BITS-1:0] tx_ff, ty_ff;
   logic signed [COORD_BITS-1:0] cre_ff, cim_ff;

   logic [NUM_BITS-1:0] num;
   logic [31:0]         den;
   logic                div_done;
   logic [NUM_BITS-1:0] quot;
   logic signed [NUM_BITS-1:0] t_sel, t_mag;
   logic signed [WW-1:0] qz, c1, c2, c3;
   logic signed [31:0]   off_sel;
   logic [63:0]          vh_prod;

   function automatic logic signed [WW-1:0] sat_c(input logic signed [WW-1:0] v);
      if (v > CMAX_W) return CMAX_W;
      if (v < CMIN_W) return CMIN_W;
      return v;
   endfunction

   // view height 2*vw/3 by reciprocal multiplication
   always_comb begin
      vh_prod = 64'({view_width, 1'b0}) * 64'(mbe_pkg::THIRD_RECIP);
   end

   always_comb begin
      t_sel = (state_ff == mbe_pkg::F_XZ) ? tx_ff : ty_ff;
      t_mag = t_sel[NUM_BITS-1] ? -t_sel : t_sel;
      num = '0;
      den = 32'd1;
      unique case (state_ff)
         mbe_pkg::F_XQ: begin
            num = NUM_BITS'(view_width) * NUM_BITS'(col_ff);
            den = (frame_width == '0) ? 32'd1 : 32'(frame_width);
         end
         mbe_pkg::F_YQ: begin
            num = NUM_BITS'(vh_ff) * NUM_BITS'(row_ff);
            den = (frame_height == '0) ? 32'd1 : 32'(frame_height);
         end
         mbe_pkg::F_XZ, mbe_pkg::F_YZ: begin
            num = NUM_BITS'(t_mag) << 16;
            den = (zoom_factor == '0) ? 32'd1 : zoom_factor;
         end
         default: begin
         end
      endcase
   end

   mbe_div #(.NUM_BITS(NUM_BITS)) u_div (
      .clock(clock), .reset(reset), .start(go_ff), .num(num), .den(den),
      .done(div_done), .quot(quot)
   );

   // quotient of the zoom step, signed, then pan and clamp; the real part also gets -0.75
   always_comb begin
      off_sel = (state_ff == mbe_pkg::F_XZ) ? x_offset : y_offset;
      qz = t_sel[NUM_BITS-1] ? -$signed(WW'({1'b0, quot})) : $signed(WW'({1'b0, quot}));
      c1 = sat_c(qz);
      c2 = sat_c(c1 + WW'(off_sel));
      c3 = sat_c(c2 - WW'($signed(mbe_pkg::THREE_QUARTERS)));
   end

   always_comb begin
      state_in = state_ff;
      go_in = 1'b0;
      q_push = 1'b0;
      unique case (state_ff)
         mbe_pkg::F_IDLE: begin
            if (start) state_in = mbe_pkg::F_VH;
         end
         mbe_pkg::F_VH: begin
            state_in = mbe_pkg::F_XQ;
            go_in = 1'b1;
         end
         mbe_pkg::F_XQ: begin
            if (div_done) begin
               state_in = mbe_pkg::F_YQ;
               go_in = 1'b1;
            end
         end
         mbe_pkg::F_YQ: begin
            if (div_done) begin
               state_in = mbe_pkg::F_XZ;
               go_in = 1'b1;
            end
         end
         mbe_pkg::F_XZ: begin
            if (div_done) begin
               state_in = mbe_pkg::F_YZ;
               go_in = 1'b1;
            end
         end
         mbe_pkg::F_YZ: begin
            if (div_done) state_in = mbe_pkg::F_PUSH;
         end
         mbe_pkg::F_PUSH: begin
            if (!q_status.full) begin
               q_push = 1'b1;
               state_in = mbe_pkg::F_IDLE;
            end
         end
         default: state_in = mbe_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbe_pkg::F_IDLE;
         go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
      end
      if (state_ff == mbe_pkg::F_IDLE && start) begin
         col_ff <= pixel_column;
         row_ff <= pixel_row;
      end
      if (state_ff == mbe_pkg::F_VH) vh_ff <= vh_prod[63:33];
      if (div_done) begin
         unique case (state_ff)
            mbe_pkg::F_XQ: tx_ff <= $signed(quot) - $signed(NUM_BITS'(view_width >> 1));
            mbe_pkg::F_YQ: ty_ff <= $signed(quot) - $signed(NUM_BITS'(vh_ff >> 1));
            mbe_pkg::F_XZ: cre_ff <= COORD_BITS'(c3);
            mbe_pkg::F_YZ: cim_ff <= COORD_BITS'(c2);
            default: begin
            end
         endcase
      end
   end

   assign busy = (state_ff != mbe_pkg::F_IDLE);
   assign q_data = {cre_ff, cim_ff};

endmodule

@@ src/mbe_queue.sv @@
module mbe_queue #(
   parameter int DATA_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_BITS-1:0]       din,
   input  logic                       pop,
   output logic [DATA_BITS-1:0]       dout,
   output mbe_pkg::queue_status_type  status
);

   logic [DATA_BITS-1:0] mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) mem_ff[wp_ff] <= din;
   end

   assign dout = mem_ff[rp_ff];
   assign status.full = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);

endmodule

@@ src/mbe_back.sv @@
module mbe_back #(
   parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = mbe_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mbe_pkg::queue_status_type  q_status,
   input  logic [2*COORD_BITS-1:0]    q_data,
   output logic                       q_pop,
   input  logic [15:0]                iteration_limit,
   output logic                       rsp_valid,
   output logic [15:0]                rsp_iteration_count,
   output logic                       rsp_escaped
);

   localparam int SW = (2*COORD_BITS + 2 > 62) ? 2*COORD_BITS + 2 : 62;
   localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic signed [SW-1:0] TWO_W = SW'(64'sd2 <<< mbe_pkg::FRAC_BITS);
   localparam logic signed [SW-1:0] FOUR_SQ = SW'(64'sd4 <<< (2*mbe_pkg::FRAC_BITS));
   localparam logic signed [SW-1:0] CMAX_S =
      {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] CMIN_S = ~CMAX_S;

   mbe_pkg::back_state_type state_ff, state_in;
   logic signed [COORD_BITS-1:0] cre_ff, cim_ff, a_ff, b_ff;
   logic signed [SW-1:0] aa_ff, bb_ff, ab_ff;
   logic [COUNT_BITS-1:0] iter_ff;
   logic                  out_v_ff, out_v_in;
   logic [15:0]           out_cnt_ff;
   logic                  out_esc_ff;

   logic [LW-1:0]         lim_w, cmask_w, limit_eff;
   logic signed [SW-1:0]  a_w, b_w, na, nb;
   logic                  big, over, finish;

   function automatic logic signed [SW-1:0] sat_c(input logic signed [SW-1:0] v);
      if (v > CMAX_S) return CMAX_S;
      if (v < CMIN_S) return CMIN_S;
      return v;
   endfunction

   always_comb begin
      lim_w = LW'(iteration_limit);
      cmask_w = LW'({COUNT_BITS{1'b1}});
      limit_eff = (lim_w > cmask_w) ? cmask_w : lim_w;
      a_w = SW'(a_ff);
      b_w = SW'(b_ff);
      big = (a_w > TWO_W) || (a_w < -TWO_W) || (b_w > TWO_W) || (b_w < -TWO_W);
      over = (aa_ff + bb_ff) > FOUR_SQ;
      na = sat_c(((aa_ff - bb_ff) >>> mbe_pkg::FRAC_BITS) + SW'(cre_ff));
      nb = sat_c((ab_ff >>> (mbe_pkg::FRAC_BITS - 1)) + SW'(cim_ff));
   end

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      finish = 1'b0;
      unique case (state_ff)
         mbe_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               state_in = mbe_pkg::B_CHECK;
            end
         end
         mbe_pkg::B_CHECK: begin
            if (LW'(iter_ff) >= limit_eff || big) begin
               finish = 1'b1;
               state_in = mbe_pkg::B_IDLE;
            end else begin
               state_in = mbe_pkg::B_UPDATE;
            end
         end
         mbe_pkg::B_UPDATE: begin
            if (over) begin
               finish = 1'b1;
               state_in = mbe_pkg::B_IDLE;
            end else begin
               state_in = mbe_pkg::B_CHECK;
            end
         end
         default: state_in = mbe_pkg::B_IDLE;
      endcase
      out_v_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbe_pkg::B_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      if (q_pop) begin
         cre_ff <= q_data[2*COORD_BITS-1:COORD_BITS];
         cim_ff <= q_data[COORD_BITS-1:0];
         a_ff <= '0;
         b_ff <= '0;
         iter_ff <= '0;
      end
      if (state_ff == mbe_pkg::B_CHECK) begin
         aa_ff <= a_w * a_w;
         bb_ff <= b_w * b_w;
         ab_ff <= a_w * b_w;
      end
      if (state_ff == mbe_pkg::B_UPDATE && !over) begin
         a_ff <= COORD_BITS'(na);
         b_ff <= COORD_BITS'(nb);
         iter_ff <= iter_ff + COUNT_BITS'(1);
      end
      if (finish) begin
         out_cnt_ff <= 16'(LW'(iter_ff));
         out_esc_ff <= (LW'(iter_ff) < limit_eff);
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_iteration_count = out_cnt_ff;
   assign rsp_escaped = out_esc_ff;

endmodule

@@ src/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time unit.
// Input: raise start with req_pixel_column/req_pixel_row; the item is taken
// at the first rising edge where busy is low. Output: rsp_valid is high for one
// cycle with rsp_iteration_count and rsp_escaped; the receiver cannot stall and
// must take it then.
// Configuration: csr_wr_en/csr_index/csr_wdata write one register per cycle;
// the user writes only while no item is in flight, which is not enforced.
// Reset restores the default view (3.5 wide, zoom 1.0, limit 256, 800x600
// frame) and empties the unit. The front gets the view height by a reciprocal
// multiply, then maps the pixel with one shared bit-serial divider through four
// divisions in turn and hands the point to the back through a two-entry queue.
// The busy output stays high from accept until that push, also while the queue
// is full, so the next item is taken only after the last one has been pushed.
// The back pops a point, then alternates a check state (iteration limit, |re| or
// |im| above 2, products registered) and an update state (magnitude test, else
// z = z*z + c). The front can map the next item while the back iterates on the
// last one.
module mandelbrot_escape_time #(
   parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = mbe_pkg::COUNT_BITS_DEF,
   parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [PIXEL_BITS-1:0]               req_pixel_column,
   input  logic [PIXEL_BITS-1:0]               req_pixel_row,
   output logic                                rsp_valid,
   output logic [15:0]                         rsp_iteration_count,
   output logic                                rsp_escaped,
   input  logic                                csr_wr_en,
   input  logic [mbe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [30:0]        view_width_ff;
   logic [31:0]        zoom_ff;
   logic signed [31:0] x_offset_ff, y_offset_ff;
   logic [15:0]        limit_ff;
   logic [12:0]        frame_w_ff, frame_h_ff;

   mbe_pkg::queue_status_type q_status;
   logic                      q_push, q_pop;
   logic [2*COORD_BITS-1:0]   q_din, q_dout;
   logic                      front_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= mbe_pkg::VIEW_WIDTH_RST;
         zoom_ff <= mbe_pkg::ZOOM_RST;
         x_offset_ff <= '0;
         y_offset_ff <= '0;
         limit_ff <= mbe_pkg::LIMIT_RST;
         frame_w_ff <= mbe_pkg::FRAME_WIDTH_RST;
         frame_h_ff <= mbe_pkg::FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::CSR_VIEW_WIDTH: view_width_ff <= csr_wdata[30:0];
            mbe_pkg::CSR_ZOOM:       zoom_ff <= csr_wdata;
            mbe_pkg::CSR_X_OFFSET:   x_offset_ff <= $signed(csr_wdata);
            mbe_pkg::CSR_Y_OFFSET:   y_offset_ff <= $signed(csr_wdata);
            mbe_pkg::CSR_LIMIT:      limit_ff <= csr_wdata[15:0];
            mbe_pkg::CSR_FRAME_W:    frame_w_ff <= csr_wdata[12:0];
            mbe_pkg::CSR_FRAME_H:    frame_h_ff <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   mbe_front #(.COORD_BITS(COORD_BITS), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock(clock), .reset(reset), .start(start),
      .pixel_column(req_pixel_column), .pixel_row(req_pixel_row),
      .busy(front_busy),
      .view_width(view_width_ff), .zoom_factor(zoom_ff),
      .x_offset(x_offset_ff), .y_offset(y_offset_ff),
      .frame_width(frame_w_ff), .frame_height(frame_h_ff),
      .q_status(q_status), .q_push(q_push), .q_data(q_din)
   );

   mbe_queue #(.DATA_BITS(2*COORD_BITS)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .din(q_din),
      .pop(q_pop), .dout(q_dout), .status(q_status)
   );

   mbe_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock(clock), .reset(reset), .q_status(q_status), .q_data(q_dout),
      .q_pop(q_pop), .iteration_limit(limit_ff),
      .rsp_valid(rsp_valid), .rsp_iteration_count(rsp_iteration_count),
      .rsp_escaped(rsp_escaped)
   );

   assign busy = front_busy;

endmodule
